// ===== rtl/core/lcpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Position fusion package
// Shared constants, history entry layout, sequencer states and ring helpers.
// ----------------------------------------------------------------------------
package lcpf_pkg;

   // History ring geometry.
   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
   localparam int ENTRIES_W  = 7;

   // Item kinds.
   localparam logic [1:0] KIND_WHEEL  = 2'd0;
   localparam logic [1:0] KIND_CAMERA = 2'd1;
   localparam logic [1:0] KIND_RESET  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_APPLIED  = 2'd0;
   localparam logic [1:0] STAT_CAM_OLD  = 2'd1;
   localparam logic [1:0] STAT_BACKWARD = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_WHEEL_TRUST = 2'd0;
   localparam logic [1:0] REG_WINDOW_MS   = 2'd1;
   localparam logic [1:0] REG_OFFSET_X    = 2'd2;
   localparam logic [1:0] REG_OFFSET_Y    = 2'd3;

   // Reset values of the registers.
   localparam logic [16:0] TRUST_RESET  = 17'd49152;
   localparam logic [15:0] WINDOW_RESET = 16'd1000;
   localparam logic [16:0] TRUST_ONE    = 17'd65536;

   // One history entry as stored in the ring.
   typedef struct packed {
      logic [31:0]        tstamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
   } entry_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD_NEW,
      ST_CHK,
      ST_MUL,
      ST_DIV_SET,
      ST_DIV,
      ST_ADD,
      ST_WHEEL_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_BL_MUL1,
      ST_BL_MUL2,
      ST_BL_RND,
      ST_BL_WR,
      ST_RP_RD,
      ST_RP_LD,
      ST_RP_WR,
      ST_PR_RD,
      ST_PR_CHK,
      ST_FIN_RD,
      ST_FIN
   } fsm_type;

   // Ring slot that lies k entries after the oldest one.
   function automatic logic [HIST_AW-1:0] slot_of(input logic [HIST_AW-1:0] oldest,
                                                  input logic [CNT_W-1:0] k);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(oldest) + (CNT_W + 1)'(k);
      if (sum >= (CNT_W + 1)'(HIST_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(HIST_DEPTH);
      end
      return sum[HIST_AW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcpf_hist_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// History store
// Single write port, single registered read port memory of history entries.
// ----------------------------------------------------------------------------
module lcpf_hist_store (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire  [lcpf_pkg::HIST_AW-1:0]      wr_addr,
   input  lcpf_pkg::entry_type               wr_data,
   input  wire                               rd_en,
   input  wire  [lcpf_pkg::HIST_AW-1:0]      rd_addr,
   output lcpf_pkg::entry_type               rd_data
);

   lcpf_pkg::entry_type mem [lcpf_pkg::HIST_DEPTH];
   lcpf_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/latency_compensated_position_fusion_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Latency compensated position fusion core
// Keeps a ring of position history, integrates wheel velocity, blends late
// camera fixes into the past and replays the newer history.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Words
//  request   start / busy              req_kind .. req_cam_latency_ms
//  response  rsp_strobe (one cycle)    rsp_est_x, rsp_est_y, rsp_status, rsp_entries
//  control   csr_write_en              csr_index, csr_wdata
//
// After reset the core writes the first history entry, with busy high. A word
// is taken when start is high and busy is low; busy then stays high until the
// response strobe. Each velocity integration goes through one shared multiplier
// and a 4 bit per cycle divider by 1000, one axis after the other; a blend runs
// each axis through two multiply states and a rounding state on the same
// multiplier. A wheel word integrates and writes its entry, then the window
// check reads the oldest entry and prunes it while it is too old; a camera word
// scans the entries, blends the first one not older than the capture time and
// replays every newer entry. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module latency_compensated_position_fusion_core (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [1:0]         req_kind,
   input  wire  [31:0]        req_now_ms,
   input  wire  signed [23:0] req_vel_x,
   input  wire  signed [23:0] req_vel_y,
   input  wire  signed [31:0] req_cam_x,
   input  wire  signed [31:0] req_cam_y,
   input  wire  [15:0]        req_cam_latency_ms,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_est_x,
   output logic signed [31:0] rsp_est_y,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_entries,
   input  wire                csr_write_en,
   input  wire  [1:0]         csr_index,
   input  wire  [31:0]        csr_wdata
);

   localparam int AW      = lcpf_pkg::HIST_AW;
   localparam int CW      = lcpf_pkg::CNT_W;
   localparam int DIV_W   = 56;
   localparam int DIV_ITER = DIV_W / 4;
   localparam int IT_W    = $clog2(DIV_ITER);
   localparam logic [10:0] MS_DIV = 11'd1000;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Configuration registers.
   logic [16:0]        trust_ff;
   logic [15:0]        window_ff;
   logic signed [31:0] offx_ff;
   logic signed [31:0] offy_ff;

   // Control state.
   lcpf_pkg::fsm_type state_ff, state_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     k_ff, k_in;
   logic              rsp_strobe_ff;

   // Item and working registers.
   logic [1:0]          kind_ff;
   logic [31:0]         now_ff;
   logic signed [23:0]  vx_ff, vy_ff;
   logic signed [31:0]  cx_ff, cy_ff;
   logic [15:0]         lat_ff;
   logic [1:0]          status_ff;
   lcpf_pkg::entry_type cur_ff;
   logic [31:0]         prev_t_ff;
   logic signed [31:0]  prev_x_ff, prev_y_ff;
   logic signed [31:0]  res_x_ff, res_y_ff;
   logic                axis_ff;
   logic signed [65:0]  prod_ff;
   logic [DIV_W-1:0]    dvd_ff;
   logic [9:0]          rem_ff;
   logic                neg_ff;
   logic [IT_W-1:0]     iter_ff;
   logic signed [31:0]  rsp_x_ff, rsp_y_ff;
   logic [1:0]          rsp_status_ff;
   logic [6:0]          rsp_entries_ff;

   // Memory port signals.
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   lcpf_pkg::entry_type wr_data, rd_q;

   // Derived values.
   logic [16:0]         w_eff;
   logic [31:0]         cap_t, cutoff_t, dt;
   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   logic [AW-1:0]       oldest_inc;
   logic                same_t;

   lcpf_hist_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign w_eff      = (trust_ff > lcpf_pkg::TRUST_ONE) ? lcpf_pkg::TRUST_ONE : trust_ff;
   assign cap_t      = (now_ff >= 32'(lat_ff)) ? now_ff - 32'(lat_ff) : 32'd0;
   assign cutoff_t   = now_ff - 32'(window_ff);
   assign dt         = cur_ff.tstamp - prev_t_ff;
   assign oldest_inc = (oldest_ff == AW'(lcpf_pkg::HIST_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign same_t     = (cur_ff.tstamp == prev_t_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         lcpf_pkg::ST_MUL: begin
            mul_a = axis_ff ? 33'(cur_ff.vel_y) : 33'(cur_ff.vel_x);
            mul_b = $signed({1'b0, dt});
         end
         lcpf_pkg::ST_BL_MUL1: begin
            mul_a = axis_ff ? 33'(cur_ff.pos_y) : 33'(cur_ff.pos_x);
            mul_b = $signed({16'd0, w_eff});
         end
         lcpf_pkg::ST_BL_MUL2: begin
            mul_a = axis_ff ? 33'(cy_ff) : 33'(cx_ff);
            mul_b = $signed({16'd0, lcpf_pkg::TRUST_ONE - w_eff});
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Four quotient bits of the divide by 1000 per cycle.
   logic [DIV_W-1:0] div_d;
   logic [9:0]       div_r;
   logic [10:0]      div_t;
   always_comb begin
      div_d = dvd_ff;
      div_r = rem_ff;
      div_t = '0;
      for (int i = 0; i < 4; i++) begin
         div_t = {div_r, div_d[DIV_W-1]};
         div_d = {div_d[DIV_W-2:0], 1'b0};
         if (div_t >= MS_DIV) begin
            div_r    = 10'(div_t - MS_DIV);
            div_d[0] = 1'b1;
         end else begin
            div_r = div_t[9:0];
         end
      end
   end

   // Rounding of the blend sum and of the integration step.
   logic signed [65:0] bl_mag, bl_q, add_q;
   always_comb begin
      bl_mag = prod_ff[65] ? -prod_ff : prod_ff;
      bl_q   = (bl_mag + 66'sd32768) >>> 16;
      if (prod_ff[65]) begin
         bl_q = -bl_q;
      end
      add_q = $signed({10'd0, dvd_ff});
      if (neg_ff) begin
         add_q = -add_q;
      end
   end

   // Sequencer: next state, ring pointers and memory ports.
   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = cur_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      case (state_ff)
         lcpf_pkg::ST_INIT: begin
            wr_en     = 1'b1;
            wr_data   = '{tstamp: 32'd0, pos_x: offx_ff, pos_y: offy_ff,
                          vel_x: 24'sd0, vel_y: 24'sd0};
            oldest_in = '0;
            count_in  = CW'(1);
            state_in  = lcpf_pkg::ST_IDLE;
         end
         lcpf_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lcpf_pkg::ST_RD_NEW;
            end
         end
         lcpf_pkg::ST_RD_NEW: begin
            rd_en    = 1'b1;
            rd_addr  = lcpf_pkg::slot_of(oldest_ff, CW'(count_ff - 1'b1));
            state_in = lcpf_pkg::ST_CHK;
         end
         lcpf_pkg::ST_CHK: begin
            if (kind_ff == lcpf_pkg::KIND_RESET) begin
               wr_en     = 1'b1;
               wr_data   = '{tstamp: now_ff, pos_x: offx_ff, pos_y: offy_ff,
                             vel_x: 24'sd0, vel_y: 24'sd0};
               oldest_in = '0;
               count_in  = CW'(1);
               state_in  = lcpf_pkg::ST_FIN_RD;
            end else if (kind_ff != lcpf_pkg::KIND_WHEEL &&
                         kind_ff != lcpf_pkg::KIND_CAMERA) begin
               state_in = lcpf_pkg::ST_FIN_RD;
            end else if (now_ff < rd_q.tstamp) begin
               state_in = lcpf_pkg::ST_FIN_RD;
            end else if (kind_ff == lcpf_pkg::KIND_WHEEL) begin
               state_in = lcpf_pkg::ST_MUL;
            end else begin
               k_in     = '0;
               state_in = lcpf_pkg::ST_SCAN_RD;
            end
         end
         lcpf_pkg::ST_MUL: begin
            state_in = lcpf_pkg::ST_DIV_SET;
         end
         lcpf_pkg::ST_DIV_SET: begin
            state_in = lcpf_pkg::ST_DIV;
         end
         lcpf_pkg::ST_DIV: begin
            if (iter_ff == IT_W'(DIV_ITER - 1)) begin
               state_in = lcpf_pkg::ST_ADD;
            end
         end
         lcpf_pkg::ST_ADD: begin
            if (!axis_ff) begin
               state_in = lcpf_pkg::ST_MUL;
            end else if (kind_ff == lcpf_pkg::KIND_WHEEL) begin
               state_in = lcpf_pkg::ST_WHEEL_WR;
            end else begin
               state_in = lcpf_pkg::ST_RP_WR;
            end
         end
         lcpf_pkg::ST_WHEEL_WR: begin
            // A new time appends (the full ring drops its oldest), a repeated
            // time rewrites the newest entry.
            wr_en   = 1'b1;
            wr_data = '{tstamp: cur_ff.tstamp, pos_x: res_x_ff, pos_y: res_y_ff,
                        vel_x: cur_ff.vel_x, vel_y: cur_ff.vel_y};
            if (same_t) begin
               wr_addr = lcpf_pkg::slot_of(oldest_ff, CW'(count_ff - 1'b1));
            end else begin
               wr_addr = lcpf_pkg::slot_of(oldest_ff, count_ff);
               if (count_ff >= CW'(lcpf_pkg::HIST_DEPTH)) begin
                  oldest_in = oldest_inc;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = lcpf_pkg::ST_PR_RD;
         end
         lcpf_pkg::ST_SCAN_RD: begin
            if (k_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lcpf_pkg::slot_of(oldest_ff, k_ff);
               state_in = lcpf_pkg::ST_SCAN_CHK;
            end else begin
               state_in = lcpf_pkg::ST_FIN_RD;
            end
         end
         lcpf_pkg::ST_SCAN_CHK: begin
            if (rd_q.tstamp < cap_t) begin
               k_in     = k_ff + 1'b1;
               state_in = lcpf_pkg::ST_SCAN_RD;
            end else begin
               state_in = lcpf_pkg::ST_BL_MUL1;
            end
         end
         lcpf_pkg::ST_BL_MUL1: begin
            state_in = lcpf_pkg::ST_BL_MUL2;
         end
         lcpf_pkg::ST_BL_MUL2: begin
            state_in = lcpf_pkg::ST_BL_RND;
         end
         lcpf_pkg::ST_BL_RND: begin
            state_in = axis_ff ? lcpf_pkg::ST_BL_WR : lcpf_pkg::ST_BL_MUL1;
         end
         lcpf_pkg::ST_BL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = lcpf_pkg::slot_of(oldest_ff, k_ff);
            wr_data  = '{tstamp: cur_ff.tstamp, pos_x: res_x_ff, pos_y: res_y_ff,
                         vel_x: cur_ff.vel_x, vel_y: cur_ff.vel_y};
            k_in     = k_ff + 1'b1;
            state_in = lcpf_pkg::ST_RP_RD;
         end
         lcpf_pkg::ST_RP_RD: begin
            if (k_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lcpf_pkg::slot_of(oldest_ff, k_ff);
               state_in = lcpf_pkg::ST_RP_LD;
            end else begin
               state_in = lcpf_pkg::ST_PR_RD;
            end
         end
         lcpf_pkg::ST_RP_LD: begin
            state_in = lcpf_pkg::ST_MUL;
         end
         lcpf_pkg::ST_RP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = lcpf_pkg::slot_of(oldest_ff, k_ff);
            wr_data  = '{tstamp: cur_ff.tstamp, pos_x: res_x_ff, pos_y: res_y_ff,
                         vel_x: cur_ff.vel_x, vel_y: cur_ff.vel_y};
            k_in     = k_ff + 1'b1;
            state_in = lcpf_pkg::ST_RP_RD;
         end
         lcpf_pkg::ST_PR_RD: begin
            if (now_ff >= 32'(window_ff) && count_ff > CW'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = oldest_ff;
               state_in = lcpf_pkg::ST_PR_CHK;
            end else begin
               state_in = lcpf_pkg::ST_FIN_RD;
            end
         end
         lcpf_pkg::ST_PR_CHK: begin
            if (rd_q.tstamp < cutoff_t) begin
               oldest_in = oldest_inc;
               count_in  = count_ff - 1'b1;
               state_in  = lcpf_pkg::ST_PR_RD;
            end else begin
               state_in = lcpf_pkg::ST_FIN_RD;
            end
         end
         lcpf_pkg::ST_FIN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = lcpf_pkg::slot_of(oldest_ff, CW'(count_ff - 1'b1));
            state_in = lcpf_pkg::ST_FIN;
         end
         lcpf_pkg::ST_FIN: begin
            state_in = lcpf_pkg::ST_IDLE;
         end
         default: begin
            state_in = lcpf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcpf_pkg::ST_INIT;
         oldest_ff     <= '0;
         count_ff      <= CW'(1);
         k_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= (state_ff == lcpf_pkg::ST_FIN);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         trust_ff  <= lcpf_pkg::TRUST_RESET;
         window_ff <= lcpf_pkg::WINDOW_RESET;
         offx_ff   <= '0;
         offy_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            lcpf_pkg::REG_WHEEL_TRUST: trust_ff  <= csr_wdata[16:0];
            lcpf_pkg::REG_WINDOW_MS:   window_ff <= csr_wdata[15:0];
            lcpf_pkg::REG_OFFSET_X:    offx_ff   <= $signed(csr_wdata);
            lcpf_pkg::REG_OFFSET_Y:    offy_ff   <= $signed(csr_wdata);
            default:                   trust_ff  <= trust_ff;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         lcpf_pkg::ST_IDLE: begin
            if (start) begin
               kind_ff   <= req_kind;
               now_ff    <= req_now_ms;
               vx_ff     <= req_vel_x;
               vy_ff     <= req_vel_y;
               cx_ff     <= req_cam_x;
               cy_ff     <= req_cam_y;
               lat_ff    <= req_cam_latency_ms;
               status_ff <= lcpf_pkg::STAT_APPLIED;
            end
         end
         lcpf_pkg::ST_CHK: begin
            if ((kind_ff == lcpf_pkg::KIND_WHEEL || kind_ff == lcpf_pkg::KIND_CAMERA) &&
                now_ff < rd_q.tstamp) begin
               status_ff <= lcpf_pkg::STAT_BACKWARD;
            end
            // The newest entry is the base of the wheel step.
            prev_t_ff    <= rd_q.tstamp;
            prev_x_ff    <= rd_q.pos_x;
            prev_y_ff    <= rd_q.pos_y;
            cur_ff       <= '{tstamp: now_ff, pos_x: rd_q.pos_x, pos_y: rd_q.pos_y,
                              vel_x: vx_ff, vel_y: vy_ff};
            axis_ff      <= 1'b0;
         end
         lcpf_pkg::ST_MUL: begin
            prod_ff <= mul_p;
         end
         lcpf_pkg::ST_DIV_SET: begin
            neg_ff  <= prod_ff[65];
            dvd_ff  <= DIV_W'(prod_ff[65] ? -prod_ff : prod_ff) + DIV_W'(500);
            rem_ff  <= '0;
            iter_ff <= '0;
         end
         lcpf_pkg::ST_DIV: begin
            dvd_ff  <= div_d;
            rem_ff  <= div_r;
            iter_ff <= iter_ff + 1'b1;
         end
         lcpf_pkg::ST_ADD: begin
            if (axis_ff) begin
               res_y_ff <= sat32(66'(prev_y_ff) + add_q);
            end else begin
               res_x_ff <= sat32(66'(prev_x_ff) + add_q);
            end
            axis_ff <= ~axis_ff;
         end
         lcpf_pkg::ST_SCAN_RD: begin
            if (k_ff >= count_ff) begin
               status_ff <= lcpf_pkg::STAT_CAM_OLD;
            end
         end
         lcpf_pkg::ST_SCAN_CHK: begin
            cur_ff  <= rd_q;
            axis_ff <= 1'b0;
         end
         lcpf_pkg::ST_BL_MUL1: begin
            prod_ff <= mul_p;
         end
         lcpf_pkg::ST_BL_MUL2: begin
            prod_ff <= prod_ff + mul_p;
         end
         lcpf_pkg::ST_BL_RND: begin
            if (axis_ff) begin
               res_y_ff <= sat32(bl_q);
            end else begin
               res_x_ff <= sat32(bl_q);
            end
            axis_ff <= ~axis_ff;
         end
         lcpf_pkg::ST_BL_WR, lcpf_pkg::ST_RP_WR: begin
            // The entry just written is the base of the next replay step.
            prev_t_ff <= cur_ff.tstamp;
            prev_x_ff <= res_x_ff;
            prev_y_ff <= res_y_ff;
         end
         lcpf_pkg::ST_RP_LD: begin
            cur_ff  <= rd_q;
            axis_ff <= 1'b0;
         end
         lcpf_pkg::ST_FIN: begin
            rsp_x_ff       <= rd_q.pos_x;
            rsp_y_ff       <= rd_q.pos_y;
            rsp_status_ff  <= status_ff;
            rsp_entries_ff <= lcpf_pkg::ENTRIES_W'(count_ff);
         end
         default: begin
            axis_ff <= axis_ff;
         end
      endcase
   end

   assign busy        = (state_ff != lcpf_pkg::ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_est_x   = rsp_x_ff;
   assign rsp_est_y   = rsp_y_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_entries = rsp_entries_ff;

endmodule
`default_nettype wire

// ===== tb/latency_compensated_position_fusion_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position fusion core testbench
// Sends wheel, camera and reset words to the core through several register
// settings. A directed table and a long run of random history sequences are
// checked against typed-in results or a predictor of the history ring.
// ----------------------------------------------------------------------------
module latency_compensated_position_fusion_core_tb;

   localparam int DEPTH      = 64;
   localparam int STALL_MAX  = 20000;
   localparam int RAND_ITEMS = 1820;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   wire                busy;
   logic [1:0]         req_kind = lcpf_pkg::KIND_WHEEL;
   logic [31:0]        req_now_ms = '0;
   logic signed [23:0] req_vel_x = '0;
   logic signed [23:0] req_vel_y = '0;
   logic signed [31:0] req_cam_x = '0;
   logic signed [31:0] req_cam_y = '0;
   logic [15:0]        req_cam_latency_ms = '0;
   wire                rsp_strobe;
   wire signed [31:0]  rsp_est_x;
   wire signed [31:0]  rsp_est_y;
   wire [1:0]          rsp_status;
   wire [6:0]          rsp_entries;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = lcpf_pkg::REG_WHEEL_TRUST;
   logic [31:0]        csr_wdata = '0;

   latency_compensated_position_fusion_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_now_ms(req_now_ms), .req_vel_x(req_vel_x),
      .req_vel_y(req_vel_y), .req_cam_x(req_cam_x), .req_cam_y(req_cam_y),
      .req_cam_latency_ms(req_cam_latency_ms), .rsp_strobe(rsp_strobe),
      .rsp_est_x(rsp_est_x), .rsp_est_y(rsp_est_y), .rsp_status(rsp_status),
      .rsp_entries(rsp_entries), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // One expected result word.
   typedef struct {
      int         est_x;
      int         est_y;
      logic [1:0] status;
      logic [6:0] entries;
   } estimate_type;

   // One directed stimulus row; has_exp marks a typed-in result.
   typedef struct {
      logic [1:0]   kind;
      logic [31:0]  now_ms;
      int           vel_x;
      int           vel_y;
      int           cam_x;
      int           cam_y;
      logic [15:0]  latency;
      bit           has_exp;
      estimate_type exp;
   } row_type;

   estimate_type pending_estimates[$];
   int  n_errors;
   int  n_words;
   int  n_camera_applied;
   int  n_full_store;
   bit  idle_on;

   // Predictor copy of the history ring and the registers.
   logic [31:0] h_time[DEPTH];
   int          h_px[DEPTH];
   int          h_py[DEPTH];
   int          h_vx[DEPTH];
   int          h_vy[DEPTH];
   int          h_oldest;
   int          h_count;
   logic [16:0] m_trust;
   logic [15:0] m_window;
   int          m_off_x;
   int          m_off_y;

   function automatic int ring_slot(int k);
      return (h_oldest + k) % DEPTH;
   endfunction

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // Division rounded to nearest with ties away from zero.
   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic int integrate(int pos, int vel, logic [31:0] dt);
      return sat32(longint'(pos) + round_div(longint'(vel) * longint'({32'b0, dt}), 1000));
   endfunction

   function automatic int blend(int p, int c, longint w);
      return sat32(round_div(longint'(p) * w + longint'(c) * (65536 - w), 65536));
   endfunction

   function automatic void clear_history(logic [31:0] t);
      for (int i = 0; i < DEPTH; i++) begin
         h_time[i] = '0; h_px[i] = 0; h_py[i] = 0; h_vx[i] = 0; h_vy[i] = 0;
      end
      h_time[0] = t;
      h_px[0] = m_off_x;
      h_py[0] = m_off_y;
      h_oldest = 0;
      h_count = 1;
   endfunction

   function automatic void prune_history(logic [31:0] now);
      logic [31:0] cutoff;
      if (now < {16'b0, m_window}) return;
      cutoff = now - {16'b0, m_window};
      while (h_count > 1 && h_time[ring_slot(0)] < cutoff) begin
         h_oldest = (h_oldest + 1) % DEPTH;
         h_count--;
      end
   endfunction

   // Advances the history by one word and returns the newest estimate.
   function automatic estimate_type fuse_word(row_type r);
      estimate_type e;
      int nw, px, py, d, k, s, a, b;
      longint w;
      logic [31:0] cap;
      e.status = lcpf_pkg::STAT_APPLIED;
      nw = ring_slot(h_count - 1);
      if (r.kind == lcpf_pkg::KIND_RESET) begin
         clear_history(r.now_ms);
      end else if (r.kind <= lcpf_pkg::KIND_CAMERA && r.now_ms < h_time[nw]) begin
         e.status = lcpf_pkg::STAT_BACKWARD;
      end else if (r.kind == lcpf_pkg::KIND_WHEEL) begin
         px = integrate(h_px[nw], r.vel_x, r.now_ms - h_time[nw]);
         py = integrate(h_py[nw], r.vel_y, r.now_ms - h_time[nw]);
         if (r.now_ms != h_time[nw]) begin
            if (h_count >= DEPTH) begin
               h_oldest = (h_oldest + 1) % DEPTH;
               h_count--;
               n_full_store++;
            end
            h_count++;
         end
         d = ring_slot(h_count - 1);
         h_time[d] = r.now_ms;
         h_px[d] = px; h_py[d] = py;
         h_vx[d] = r.vel_x; h_vy[d] = r.vel_y;
         prune_history(r.now_ms);
      end else if (r.kind == lcpf_pkg::KIND_CAMERA) begin
         cap = (r.now_ms >= {16'b0, r.latency}) ? r.now_ms - {16'b0, r.latency} : '0;
         k = 0;
         while (k < h_count && h_time[ring_slot(k)] < cap) k++;
         if (k >= h_count) begin
            e.status = lcpf_pkg::STAT_CAM_OLD;
         end else begin
            w = (m_trust > lcpf_pkg::TRUST_ONE) ? 65536 : longint'({47'b0, m_trust});
            s = ring_slot(k);
            h_px[s] = blend(h_px[s], r.cam_x, w);
            h_py[s] = blend(h_py[s], r.cam_y, w);
            for (int j = k + 1; j < h_count; j++) begin
               a = ring_slot(j - 1);
               b = ring_slot(j);
               h_px[b] = integrate(h_px[a], h_vx[b], h_time[b] - h_time[a]);
               h_py[b] = integrate(h_py[a], h_vy[b], h_time[b] - h_time[a]);
            end
            prune_history(r.now_ms);
            n_camera_applied++;
         end
      end
      nw = ring_slot(h_count - 1);
      e.est_x = h_px[nw];
      e.est_y = h_py[nw];
      e.entries = 7'(h_count);
      return e;
   endfunction

   // Drives one word, waits for it to be taken and records what it must give.
   task automatic send_word(row_type r);
      estimate_type e;
      @(posedge clock);
      req_kind <= r.kind;
      req_now_ms <= r.now_ms;
      req_vel_x <= 24'(r.vel_x);
      req_vel_y <= 24'(r.vel_y);
      req_cam_x <= r.cam_x;
      req_cam_y <= r.cam_y;
      req_cam_latency_ms <= r.latency;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      e = fuse_word(r);
      pending_estimates.push_back(r.has_exp ? r.exp : e);
      n_words++;
      if (idle_on && $urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 150)) @(posedge clock);
      end
   endtask

   // Lets the core drain, then writes all four registers.
   task automatic write_registers(logic [16:0] trust, logic [15:0] window, int ox, int oy);
      while (pending_estimates.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= 2'(i);
         case (2'(i))
            lcpf_pkg::REG_WHEEL_TRUST: csr_wdata <= {15'b0, trust};
            lcpf_pkg::REG_WINDOW_MS:   csr_wdata <= {16'b0, window};
            lcpf_pkg::REG_OFFSET_X:    csr_wdata <= ox;
            default:                   csr_wdata <= oy;
         endcase
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      m_trust = trust; m_window = window; m_off_x = ox; m_off_y = oy;
   endtask

   function automatic row_type make_row(logic [1:0] kind, logic [31:0] now, int vx, int vy,
                                        int cx, int cy, logic [15:0] lat);
      row_type r;
      r.kind = kind; r.now_ms = now; r.vel_x = vx; r.vel_y = vy;
      r.cam_x = cx; r.cam_y = cy; r.latency = lat; r.has_exp = 1'b0;
      r.exp = '{0, 0, lcpf_pkg::STAT_APPLIED, 7'd0};
      return r;
   endfunction

   function automatic row_type typed(row_type r, int ex, int ey, logic [1:0] st, int n);
      r.has_exp = 1'b1;
      r.exp = '{ex, ey, st, 7'(n)};
      return r;
   endfunction

   // Random velocity: mostly modest, sometimes anywhere in the field.
   function automatic int rand_vel();
      if ($urandom_range(9) == 0) return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
      return $signed($urandom_range(0, 2 * 655360)) - 655360;
   endfunction

   function automatic int rand_pos(int near);
      if ($urandom_range(9) == 0) return int'($urandom);
      return near + $signed($urandom_range(0, 131072)) - 65536;
   endfunction

   // Random word, mostly a well-formed continuation of the present history.
   function automatic row_type rand_row();
      logic [31:0] newest, oldest_t, span;
      int pick, nw;
      nw = ring_slot(h_count - 1);
      newest = h_time[nw];
      oldest_t = h_time[ring_slot(0)];
      pick = $urandom_range(99);
      if (pick < 2) begin
         return make_row(lcpf_pkg::KIND_RESET, ($urandom_range(3) == 0) ? $urandom : newest,
                         0, 0, 0, 0, 16'($urandom));
      end else if (pick < 3) begin
         return make_row(2'd3, $urandom, rand_vel(), rand_vel(), $urandom, $urandom,
                         16'($urandom));
      end else if (pick < 7) begin
         return make_row($urandom_range(1) ? lcpf_pkg::KIND_CAMERA : lcpf_pkg::KIND_WHEEL,
                         newest - $urandom_range(1, 100), rand_vel(), rand_vel(),
                         $urandom, $urandom, 16'($urandom));
      end else if (pick < 70) begin
         return make_row(lcpf_pkg::KIND_WHEEL,
                         newest + (($urandom_range(19) == 0) ? $urandom_range(0, 5000)
                                                             : $urandom_range(0, 25)),
                         rand_vel(), rand_vel(), 0, 0, 16'($urandom));
      end else begin
         span = newest - oldest_t + $urandom_range(0, 30);
         return make_row(lcpf_pkg::KIND_CAMERA, newest + $urandom_range(0, 20), 0, 0,
                         rand_pos(h_px[nw]), rand_pos(h_py[nw]),
                         ($urandom_range(7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, span & 32'hffff)));
      end
   endfunction

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_strobe) begin
         if (pending_estimates.size() == 0) begin
            $display("%0t: unexpected result word est=(%0d,%0d) status=%0d entries=%0d",
                     $time, rsp_est_x, rsp_est_y, rsp_status, rsp_entries);
            n_errors++;
         end else begin
            e = pending_estimates.pop_front();
            if (rsp_est_x !== e.est_x) begin
               $display("%0t: est_x expected %0d got %0d", $time, e.est_x, rsp_est_x);
               n_errors++;
            end
            if (rsp_est_y !== e.est_y) begin
               $display("%0t: est_y expected %0d got %0d", $time, e.est_y, rsp_est_y);
               n_errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d got %0d", $time, e.status, rsp_status);
               n_errors++;
            end
            if (rsp_entries !== e.entries) begin
               $display("%0t: entries expected %0d got %0d", $time, e.entries, rsp_entries);
               n_errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
         $display("latency_compensated_position_fusion_core_tb NOT OK");
         $finish;
      end
   end

   row_type directed[$];

   initial begin
      n_errors = 0; n_words = 0; n_camera_applied = 0; n_full_store = 0;
      idle_on = 1'b1;
      m_trust = lcpf_pkg::TRUST_RESET; m_window = lcpf_pkg::WINDOW_RESET;
      m_off_x = 0; m_off_y = 0;
      clear_history('0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset register values.
      directed.push_back(typed(make_row(lcpf_pkg::KIND_WHEEL, 32'd0, 8388607, -8388608,
                                        0, 0, 0),
                               0, 0, lcpf_pkg::STAT_APPLIED, 1));
      directed.push_back(typed(make_row(lcpf_pkg::KIND_WHEEL, 32'd1000, 0, 0, 0, 0, 0),
                               0, 0, lcpf_pkg::STAT_APPLIED, 2));
      directed.push_back(typed(make_row(lcpf_pkg::KIND_WHEEL, 32'd500, 5, 5, 0, 0, 0),
                               0, 0, lcpf_pkg::STAT_BACKWARD, 2));
      directed.push_back(typed(make_row(lcpf_pkg::KIND_CAMERA, 32'd999, 0, 0, 7, 7, 0),
                               0, 0, lcpf_pkg::STAT_BACKWARD, 2));
      directed.push_back(typed(make_row(lcpf_pkg::KIND_CAMERA, 32'd2000, 0, 0, 65536,
                                        65536, 0),
                               0, 0, lcpf_pkg::STAT_CAM_OLD, 2));
      directed.push_back(typed(make_row(2'd3, 32'hffffffff, -1, -1, -1, -1, 16'hffff),
                               0, 0, lcpf_pkg::STAT_APPLIED, 2));
      directed.push_back(make_row(lcpf_pkg::KIND_CAMERA, 32'd1000, 0, 0, 32'sh7fffffff,
                                  32'sh80000000, 16'hffff));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'd1010, 8388607, -8388608,
                                  0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'd1020, 65536, 65536, 0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_CAMERA, 32'd1025, 0, 0, 0, 0, 16'd20));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'd1020, -65536, 3, 0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'd5000, 1000, -1000, 0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'hffffffff, 8388607, -8388608,
                                  0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_WHEEL, 32'hffffffff, -8388608, 8388607,
                                  0, 0, 0));
      directed.push_back(make_row(lcpf_pkg::KIND_CAMERA, 32'hffffffff, 0, 0, 32'sh80000000,
                                  32'sh7fffffff, 16'd0));
      directed.push_back(typed(make_row(lcpf_pkg::KIND_RESET, 32'd12345, 0, 0, 0, 0, 0),
                               0, 0, lcpf_pkg::STAT_APPLIED, 1));
      directed.push_back(make_row(lcpf_pkg::KIND_CAMERA, 32'd12345, 0, 0, 100000, -100000,
                                  16'd0));
      foreach (directed[i]) send_word(directed[i]);

      // Random part over several register settings, the extremes among them.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_registers(17'd0, 16'd65535, 32'sh7fffffff, 32'sh80000000);
            1: write_registers(17'd65536, 16'd1, 32'sh80000000, 32'sh7fffffff);
            2: write_registers(17'h1ffff, 16'd300, 0, 0);
            3: write_registers(17'(lcpf_pkg::TRUST_RESET), lcpf_pkg::WINDOW_RESET, 123456,
                               -654321);
            4: write_registers(17'($urandom), 16'($urandom_range(1, 65535)), $urandom,
                               $urandom);
            5: write_registers(17'd32768, 16'd65535, -1, 1);
            default: write_registers(17'($urandom_range(0, 65536)), 16'd2000, $urandom,
                                     $urandom);
         endcase
         idle_on = (ph != 2);
         send_word(make_row(lcpf_pkg::KIND_RESET,
                            (ph == 4) ? 32'hfff00000 : $urandom_range(0, 4000),
                            0, 0, 0, 0, 0));
         for (int i = 0; i < RAND_ITEMS / 7; i++) send_word(rand_row());
      end

      while (pending_estimates.size() != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d words over 8 register settings: %0d camera fixes replayed,",
               n_words, n_camera_applied);
      $display("%0d appends to a full history, %0d mismatches.", n_full_store, n_errors);
      if (n_errors == 0 && pending_estimates.size() == 0) begin
         $display("latency_compensated_position_fusion_core_tb OK");
      end else begin
         $display("latency_compensated_position_fusion_core_tb NOT OK");
      end
      $finish;
   end

endmodule
